// ===== rtl/fault_debounce_monitor_macros.svh =====
// assertion macros shared by the fault debounce monitor modules
`ifndef FAULT_DEBOUNCE_MONITOR_MACROS_SVH
`define FAULT_DEBOUNCE_MONITOR_MACROS_SVH

// same-cycle implication on the module clock, held off during reset
`define FDM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the module clock, held off during reset
`define FDM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fdm_pkg.sv =====
// shared types and constants of the fault debounce monitor
`default_nettype none

package fdm_pkg;

   localparam int CHANNELS_DEF  = 6;
   localparam int TIME_BITS_DEF = 24;

   localparam int REQ_W     = 2;
   localparam int CH_W      = 3;
   localparam int DETAIL_W  = 32;
   localparam int MS_W      = 24;
   localparam int OCC_W     = 16;
   localparam int SET_W     = 51;
   localparam int CNT_W     = 3;
   localparam int SEV_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam int SET_CONFIRM_LSB = 0;
   localparam int SET_RECOVER_LSB = 24;
   localparam int SET_SEV_LSB     = 48;
   localparam int SET_LATCH_BIT   = 50;

   localparam logic [CNT_W-1:0] COUNT_RESET = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTING0 = 3'd2;

   localparam logic [REQ_W-1:0] REQ_PROBE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAIL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/fdm_csr.sv =====
// configuration registers: enable, channel count and per-channel settings
`default_nettype none

module fdm_csr #(
   parameter int CHANNELS = fdm_pkg::CHANNELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fdm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fdm_pkg::SET_W-1:0]     csr_wdata,
   output logic                               enable,
   output logic [fdm_pkg::CNT_W-1:0]          used_count,
   output logic [fdm_pkg::SET_W-1:0]          setting [CHANNELS]
);
   import fdm_pkg::*;

   logic                 enable_ff, enable_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SET_W-1:0]     setting_ff [CHANNELS];
   logic [SET_W-1:0]     setting_in [CHANNELS];

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      count_in  = count_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         setting_in[c] = setting_ff[c];
      end
      if (csr_valid) begin
         if (csr_index == CSR_ENABLE) begin
            enable_in = csr_wdata[0];
         end
         if (csr_index == CSR_COUNT) begin
            count_in = csr_wdata[CNT_W-1:0];
         end
         for (int c = 0; c < CHANNELS; c++) begin
            if (csr_index == CSR_IDX_W'(int'(CSR_SETTING0) + c)) begin
               setting_in[c] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= COUNT_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            setting_ff[c] <= '0;
         end
      end else begin
         enable_ff <= enable_in;
         count_ff  <= count_in;
         for (int c = 0; c < CHANNELS; c++) begin
            setting_ff[c] <= setting_in[c];
         end
      end
   end

   assign enable     = enable_ff;
   assign used_count = (count_ff > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : count_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         setting[c] = setting_ff[c];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fdm_ctrl.sv =====
// request sequencing: capture, read-modify-write, result hand-off
`default_nettype none

module fdm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output fdm_pkg::ctrl_cmd_type cmd
);
   import fdm_pkg::*;

`include "fault_debounce_monitor_macros.svh"

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FDM_ASSERT_NXT(a_capture_goes_exec, cmd.capture, state_ff == FSM_EXEC,
      "captured request did not move to execute")
   `FDM_ASSERT_NXT(a_execute_shows_result, cmd.execute, rsp_valid_ff,
      "executed request produced no result")
   `FDM_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && rsp_stall, !cmd.execute,
      "waiting result would be overwritten")

endmodule

`default_nettype wire

// ===== rtl/fdm_datapath.sv =====
// channel state store, debounce arithmetic and result register
`default_nettype none

module fdm_datapath #(
   parameter int CHANNELS  = fdm_pkg::CHANNELS_DEF,
   parameter int TIME_BITS = fdm_pkg::TIME_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fdm_pkg::ctrl_cmd_type         cmd,
   input  wire logic                          enable,
   input  wire logic [fdm_pkg::CNT_W-1:0]     used_count,
   input  wire logic [fdm_pkg::SET_W-1:0]     setting [CHANNELS],
   input  wire logic [fdm_pkg::REQ_W-1:0]     req_type,
   input  wire logic [fdm_pkg::CH_W-1:0]      req_channel_index,
   input  wire logic                          req_healthy,
   input  wire logic [fdm_pkg::DETAIL_W-1:0]  req_probe_detail,
   input  wire logic [fdm_pkg::MS_W-1:0]      req_elapsed_ms,
   output logic [fdm_pkg::CH_W-1:0]           rsp_out_channel,
   output logic [fdm_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_fault_active,
   output logic                               rsp_latch_set,
   output logic [fdm_pkg::OCC_W-1:0]          rsp_occurrences,
   output logic [fdm_pkg::DETAIL_W-1:0]       rsp_stored_detail,
   output logic [fdm_pkg::MS_W-1:0]           rsp_fault_time,
   output logic [fdm_pkg::MS_W-1:0]           rsp_recovery_time,
   output logic                               rsp_state_changed,
   output logic [fdm_pkg::CNT_W-1:0]          rsp_active_total,
   output logic [fdm_pkg::SEV_W-1:0]          rsp_top_severity,
   output logic                               rsp_tick_done
);
   import fdm_pkg::*;

`include "fault_debounce_monitor_macros.svh"

   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WIDE_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
   localparam int SUM_W  = WIDE_W + 1;
   localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'((64'd1 << TIME_BITS) - 64'd1);

   // captured request
   logic [REQ_W-1:0]     type_ff;
   logic [CH_W-1:0]      ch_ff;
   logic                 healthy_ff;
   logic [DETAIL_W-1:0]  probe_ff;
   logic [MS_W-1:0]      elapsed_ff;

   // channel state
   logic                 active_ff [CHANNELS];
   logic                 latch_ff  [CHANNELS];
   logic [OCC_W-1:0]     occ_ff    [CHANNELS];
   logic [DETAIL_W-1:0]  detail_ff [CHANNELS];
   logic [TIME_BITS-1:0] fault_ff  [CHANNELS];
   logic [TIME_BITS-1:0] recov_ff  [CHANNELS];
   logic [CNT_W-1:0]     act_cnt_ff;
   logic [SEV_W-1:0]     peak_ff;

   // result register
   logic [CH_W-1:0]      o_ch_ff;
   logic [STATUS_W-1:0]  o_status_ff;
   logic                 o_active_ff, o_latch_ff, o_changed_ff, o_done_ff;
   logic [OCC_W-1:0]     o_occ_ff;
   logic [DETAIL_W-1:0]  o_detail_ff;
   logic [MS_W-1:0]      o_fault_ff, o_recov_ff;
   logic [CNT_W-1:0]     o_cnt_ff;
   logic [SEV_W-1:0]     o_sev_ff;

   logic [IDX_W-1:0]     idx;
   logic                 valid_ch;
   logic [SET_W-1:0]     sel_set;
   logic [MS_W-1:0]      confirm_ms, recover_ms;
   logic [SEV_W-1:0]     sev;
   logic                 latching;
   logic                 cur_act, cur_latch;
   logic [OCC_W-1:0]     cur_occ;
   logic [DETAIL_W-1:0]  cur_detail;
   logic [TIME_BITS-1:0] cur_fault, cur_recov;
   logic [SUM_W-1:0]     fault_sum, recov_sum;
   logic [TIME_BITS-1:0] fault_new, recov_new;
   logic                 fault_hit, recov_hit;
   logic [CNT_W-1:0]     base_cnt;
   logic [SEV_W-1:0]     base_peak;

   logic                 write_ch;
   logic                 act_in, latch_in, changed_in, done_in;
   logic [OCC_W-1:0]     occ_in;
   logic [DETAIL_W-1:0]  detail_in;
   logic [TIME_BITS-1:0] fault_in, recov_in;
   logic [CNT_W-1:0]     act_cnt_in;
   logic [SEV_W-1:0]     peak_in;
   logic [STATUS_W-1:0]  status_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff    <= req_type;
         ch_ff      <= req_channel_index;
         healthy_ff <= req_healthy;
         probe_ff   <= req_probe_detail;
         elapsed_ff <= req_elapsed_ms;
      end
   end

   assign idx        = ch_ff[IDX_W-1:0];
   assign valid_ch   = (ch_ff < used_count);
   assign sel_set    = setting[idx];
   assign confirm_ms = sel_set[SET_CONFIRM_LSB +: MS_W];
   assign recover_ms = sel_set[SET_RECOVER_LSB +: MS_W];
   assign sev        = sel_set[SET_SEV_LSB +: SEV_W];
   assign latching   = sel_set[SET_LATCH_BIT];
   assign cur_act    = active_ff[idx];
   assign cur_latch  = latch_ff[idx];
   assign cur_occ    = occ_ff[idx];
   assign cur_detail = detail_ff[idx];
   assign cur_fault  = fault_ff[idx];
   assign cur_recov  = recov_ff[idx];

   // saturating accumulate and threshold compare
   assign fault_sum = SUM_W'(cur_fault) + SUM_W'(elapsed_ff);
   assign recov_sum = SUM_W'(cur_recov) + SUM_W'(elapsed_ff);
   assign fault_new = TIME_BITS'((fault_sum > TIME_MAX) ? TIME_MAX : fault_sum);
   assign recov_new = TIME_BITS'((recov_sum > TIME_MAX) ? TIME_MAX : recov_sum);
   assign fault_hit = (WIDE_W'(fault_new) >= WIDE_W'(confirm_ms));
   assign recov_hit = (WIDE_W'(recov_new) >= WIDE_W'(recover_ms));

   // channel 0 opens a tick
   assign base_cnt  = (ch_ff == '0) ? '0 : act_cnt_ff;
   assign base_peak = (ch_ff == '0) ? '0 : peak_ff;

   always_comb begin
      write_ch   = 1'b0;
      act_in     = cur_act;
      latch_in   = cur_latch;
      occ_in     = cur_occ;
      detail_in  = cur_detail;
      fault_in   = cur_fault;
      recov_in   = cur_recov;
      act_cnt_in = act_cnt_ff;
      peak_in    = peak_ff;
      status_in  = STATUS_OK;
      changed_in = 1'b0;
      done_in    = 1'b0;
      if (!valid_ch) begin
         status_in = STATUS_INVALID;
      end else begin
         case (type_ff)
            REQ_PROBE: begin
               if (!enable) begin
                  status_in = STATUS_FAIL;
               end else begin
                  write_ch  = 1'b1;
                  detail_in = probe_ff;
                  if (!healthy_ff) begin
                     recov_in = '0;
                     fault_in = fault_new;
                     if (fault_hit) begin
                        act_in = 1'b1;
                        if (latching) begin
                           latch_in = 1'b1;
                        end
                        if (!cur_act) begin
                           occ_in = cur_occ + OCC_W'(1);
                        end
                     end
                  end else begin
                     fault_in = '0;
                     recov_in = recov_new;
                     if (recov_hit) begin
                        act_in = 1'b0;
                     end
                  end
                  act_cnt_in = base_cnt;
                  peak_in    = base_peak;
                  if (act_in) begin
                     if (base_cnt < CNT_W'(CHANNELS)) begin
                        act_cnt_in = base_cnt + CNT_W'(1);
                     end
                     if (sev > base_peak) begin
                        peak_in = sev;
                     end
                  end
                  changed_in = (act_in != cur_act);
                  done_in    = (({1'b0, ch_ff} + (CH_W + 1)'(1)) == {1'b0, used_count});
               end
            end
            REQ_CLEAR: begin
               if (cur_act) begin
                  status_in = STATUS_FAIL;
               end else begin
                  write_ch = 1'b1;
                  latch_in = 1'b0;
               end
            end
            REQ_QUERY: begin
               status_in = STATUS_OK;
            end
            default: begin
               status_in = STATUS_FAIL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            active_ff[c] <= 1'b0;
            latch_ff[c]  <= 1'b0;
            occ_ff[c]    <= '0;
            detail_ff[c] <= '0;
            fault_ff[c]  <= '0;
            recov_ff[c]  <= '0;
         end
         act_cnt_ff <= '0;
         peak_ff    <= '0;
      end else if (cmd.execute && write_ch) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (idx == IDX_W'(c)) begin
               active_ff[c] <= act_in;
               latch_ff[c]  <= latch_in;
               occ_ff[c]    <= occ_in;
               detail_ff[c] <= detail_in;
               fault_ff[c]  <= fault_in;
               recov_ff[c]  <= recov_in;
            end
         end
         act_cnt_ff <= act_cnt_in;
         peak_ff    <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         o_ch_ff     <= ch_ff;
         o_status_ff <= status_in;
         if (!valid_ch) begin
            o_active_ff  <= 1'b0;
            o_latch_ff   <= 1'b0;
            o_occ_ff     <= '0;
            o_detail_ff  <= '0;
            o_fault_ff   <= '0;
            o_recov_ff   <= '0;
            o_changed_ff <= 1'b0;
            o_cnt_ff     <= '0;
            o_sev_ff     <= '0;
            o_done_ff    <= 1'b0;
         end else begin
            o_active_ff  <= act_in;
            o_latch_ff   <= latch_in;
            o_occ_ff     <= occ_in;
            o_detail_ff  <= detail_in;
            o_fault_ff   <= MS_W'(WIDE_W'(fault_in));
            o_recov_ff   <= MS_W'(WIDE_W'(recov_in));
            o_changed_ff <= changed_in;
            o_cnt_ff     <= act_cnt_in;
            o_sev_ff     <= peak_in;
            o_done_ff    <= done_in;
         end
      end
   end

   assign rsp_out_channel   = o_ch_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_fault_active  = o_active_ff;
   assign rsp_latch_set     = o_latch_ff;
   assign rsp_occurrences   = o_occ_ff;
   assign rsp_stored_detail = o_detail_ff;
   assign rsp_fault_time    = o_fault_ff;
   assign rsp_recovery_time = o_recov_ff;
   assign rsp_state_changed = o_changed_ff;
   assign rsp_active_total  = o_cnt_ff;
   assign rsp_top_severity  = o_sev_ff;
   assign rsp_tick_done     = o_done_ff;

   `FDM_ASSERT_IMP(a_count_bounded, 1'b1, act_cnt_ff <= CNT_W'(CHANNELS),
      "active count above channel count")
   `FDM_ASSERT_IMP(a_write_needs_valid_channel, cmd.execute && write_ch, valid_ch,
      "channel state written for an invalid channel")
   `FDM_ASSERT_NXT(a_invalid_gives_status, cmd.execute && !valid_ch,
      o_status_ff == STATUS_INVALID, "invalid channel result without invalid status")

endmodule

`default_nettype wire

// ===== rtl/fault_debounce_monitor.sv =====
// top level of the fault debounce monitor
// a request is captured into the request registers and its result is registered in execute
// no new request is taken in execute, which does the single read-modify-write of channel state
// a stalled result holds the next request in execute until the result is taken
// reset: synchronous, clears channel state, tick totals and configuration (count reads 6)
`default_nettype none

module fault_debounce_monitor #(
   parameter int CHANNELS  = fdm_pkg::CHANNELS_DEF,
   parameter int TIME_BITS = fdm_pkg::TIME_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [fdm_pkg::REQ_W-1:0]     req_type,
   input  wire logic [fdm_pkg::CH_W-1:0]      req_channel_index,
   input  wire logic                          req_healthy,
   input  wire logic [fdm_pkg::DETAIL_W-1:0]  req_probe_detail,
   input  wire logic [fdm_pkg::MS_W-1:0]      req_elapsed_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [fdm_pkg::CH_W-1:0]           rsp_out_channel,
   output logic [fdm_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_fault_active,
   output logic                               rsp_latch_set,
   output logic [fdm_pkg::OCC_W-1:0]          rsp_occurrences,
   output logic [fdm_pkg::DETAIL_W-1:0]       rsp_stored_detail,
   output logic [fdm_pkg::MS_W-1:0]           rsp_fault_time,
   output logic [fdm_pkg::MS_W-1:0]           rsp_recovery_time,
   output logic                               rsp_state_changed,
   output logic [fdm_pkg::CNT_W-1:0]          rsp_active_total,
   output logic [fdm_pkg::SEV_W-1:0]          rsp_top_severity,
   output logic                               rsp_tick_done,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fdm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fdm_pkg::SET_W-1:0]     csr_wdata
);
   import fdm_pkg::*;

   ctrl_cmd_type     cmd;
   logic             enable;
   logic [CNT_W-1:0] used_count;
   logic [SET_W-1:0] setting [CHANNELS];

   fdm_csr #(
      .CHANNELS (CHANNELS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .enable     (enable),
      .used_count (used_count),
      .setting    (setting)
   );

   fdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   fdm_datapath #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .enable            (enable),
      .used_count        (used_count),
      .setting           (setting),
      .req_type          (req_type),
      .req_channel_index (req_channel_index),
      .req_healthy       (req_healthy),
      .req_probe_detail  (req_probe_detail),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_status        (rsp_status),
      .rsp_fault_active  (rsp_fault_active),
      .rsp_latch_set     (rsp_latch_set),
      .rsp_occurrences   (rsp_occurrences),
      .rsp_stored_detail (rsp_stored_detail),
      .rsp_fault_time    (rsp_fault_time),
      .rsp_recovery_time (rsp_recovery_time),
      .rsp_state_changed (rsp_state_changed),
      .rsp_active_total  (rsp_active_total),
      .rsp_top_severity  (rsp_top_severity),
      .rsp_tick_done     (rsp_tick_done)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench of the fault debounce monitor with a per-channel debounce predictor
`timescale 1ns / 1ps

module testbench;
   import fdm_pkg::*;

   localparam int NUM_CH = CHANNELS_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PERCENT = 23;
   localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
   localparam logic [MS_W-1:0] MS_MAX = '1;

   typedef struct packed {
      logic [REQ_W-1:0]    kind;
      logic [CH_W-1:0]     chan;
      logic                healthy;
      logic [DETAIL_W-1:0] detail;
      logic [MS_W-1:0]     elapsed;
   } request_type;

   typedef struct packed {
      logic [CH_W-1:0]     chan;
      logic [STATUS_W-1:0] status;
      logic                active;
      logic                latched;
      logic [OCC_W-1:0]    occ;
      logic [DETAIL_W-1:0] detail;
      logic [MS_W-1:0]     fault_ms;
      logic [MS_W-1:0]     recover_ms;
      logic                changed;
      logic [CNT_W-1:0]    total;
      logic [SEV_W-1:0]    peak;
      logic                done;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [REQ_W-1:0]     req_type = REQ_PROBE;
   logic [CH_W-1:0]      req_channel_index = '0;
   logic                 req_healthy = 1'b0;
   logic [DETAIL_W-1:0]  req_probe_detail = '0;
   logic [MS_W-1:0]      req_elapsed_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CH_W-1:0]      rsp_out_channel;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_fault_active;
   logic                 rsp_latch_set;
   logic [OCC_W-1:0]     rsp_occurrences;
   logic [DETAIL_W-1:0]  rsp_stored_detail;
   logic [MS_W-1:0]      rsp_fault_time;
   logic [MS_W-1:0]      rsp_recovery_time;
   logic                 rsp_state_changed;
   logic [CNT_W-1:0]     rsp_active_total;
   logic [SEV_W-1:0]     rsp_top_severity;
   logic                 rsp_tick_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SET_W-1:0]     csr_wdata = '0;

   // debounce state mirrored by the predictor
   logic             monitor_on;
   logic [CNT_W-1:0] chan_in_use;
   logic [SET_W-1:0] chan_setting [NUM_CH];
   logic             active_flag [NUM_CH];
   logic             latch_flag [NUM_CH];
   logic [OCC_W-1:0] occ_count [NUM_CH];
   logic [DETAIL_W-1:0] detail_reg [NUM_CH];
   logic [MS_W-1:0]  fault_ms [NUM_CH];
   logic [MS_W-1:0]  recover_ms [NUM_CH];
   logic [CNT_W-1:0] tick_active;
   logic [SEV_W-1:0] tick_peak;

   response_type expected_q [$];
   response_type want;
   bit calm = 1'b0;
   int fail_count = 0;
   int req_total = 0;
   int csr_total = 0;
   int phase_total = 0;
   int quiet_cycles = 0;

   fault_debounce_monitor u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_channel_index (req_channel_index),
      .req_healthy       (req_healthy),
      .req_probe_detail  (req_probe_detail),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_status        (rsp_status),
      .rsp_fault_active  (rsp_fault_active),
      .rsp_latch_set     (rsp_latch_set),
      .rsp_occurrences   (rsp_occurrences),
      .rsp_stored_detail (rsp_stored_detail),
      .rsp_fault_time    (rsp_fault_time),
      .rsp_recovery_time (rsp_recovery_time),
      .rsp_state_changed (rsp_state_changed),
      .rsp_active_total  (rsp_active_total),
      .rsp_top_severity  (rsp_top_severity),
      .rsp_tick_done     (rsp_tick_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [MS_W-1:0] sat_add(logic [MS_W-1:0] acc, logic [MS_W-1:0] inc);
      logic [MS_W:0] sum;
      sum = {1'b0, acc} + {1'b0, inc};
      return sum[MS_W] ? MS_MAX : sum[MS_W-1:0];
   endfunction

   function automatic response_type forecast_response(request_type r);
      response_type o;
      int used;
      int ch;
      logic [SET_W-1:0] set_word;
      logic [MS_W-1:0] confirm_lim;
      logic [MS_W-1:0] recover_lim;
      logic [SEV_W-1:0] sev;
      logic was_active;
      o = '0;
      o.chan = r.chan;
      ch = int'(r.chan);
      used = (chan_in_use > CNT_W'(NUM_CH)) ? NUM_CH : int'(chan_in_use);
      if (ch >= used) begin
         o.status = STATUS_INVALID;
         return o;
      end
      o.status = STATUS_OK;
      case (r.kind)
         REQ_PROBE: begin
            if (!monitor_on) begin
               o.status = STATUS_FAIL;
            end else begin
               set_word = chan_setting[ch];
               confirm_lim = set_word[SET_CONFIRM_LSB +: MS_W];
               recover_lim = set_word[SET_RECOVER_LSB +: MS_W];
               sev = set_word[SET_SEV_LSB +: SEV_W];
               was_active = active_flag[ch];
               if (ch == 0) begin
                  tick_active = '0;
                  tick_peak = '0;
               end
               detail_reg[ch] = r.detail;
               if (!r.healthy) begin
                  recover_ms[ch] = '0;
                  fault_ms[ch] = sat_add(fault_ms[ch], r.elapsed);
                  if (fault_ms[ch] >= confirm_lim) begin
                     active_flag[ch] = 1'b1;
                     if (set_word[SET_LATCH_BIT]) latch_flag[ch] = 1'b1;
                     if (!was_active) occ_count[ch] = occ_count[ch] + 1'b1;
                  end
               end else begin
                  fault_ms[ch] = '0;
                  recover_ms[ch] = sat_add(recover_ms[ch], r.elapsed);
                  if (recover_ms[ch] >= recover_lim) active_flag[ch] = 1'b0;
               end
               if (active_flag[ch]) begin
                  if (tick_active < NUM_CH) tick_active = tick_active + 1'b1;
                  if (sev > tick_peak) tick_peak = sev;
               end
               o.changed = (was_active != active_flag[ch]);
               o.done = (ch + 1 == used);
            end
         end
         REQ_CLEAR: begin
            if (active_flag[ch]) o.status = STATUS_FAIL;
            else latch_flag[ch] = 1'b0;
         end
         REQ_QUERY: begin
         end
         default: o.status = STATUS_FAIL;
      endcase
      o.active = active_flag[ch];
      o.latched = latch_flag[ch];
      o.occ = occ_count[ch];
      o.detail = detail_reg[ch];
      o.fault_ms = fault_ms[ch];
      o.recover_ms = recover_ms[ch];
      o.total = tick_active;
      o.peak = tick_peak;
      return o;
   endfunction

   function automatic void check_field(string field, longint unsigned exp_val,
                                       longint unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
         fail_count++;
      end
   endfunction

   function automatic request_type pack_request(logic [REQ_W-1:0] kind, logic [CH_W-1:0] chan,
                                                logic healthy, logic [DETAIL_W-1:0] detail,
                                                logic [MS_W-1:0] elapsed);
      request_type r;
      r.kind = kind;
      r.chan = chan;
      r.healthy = healthy;
      r.detail = detail;
      r.elapsed = elapsed;
      return r;
   endfunction

   function automatic logic [MS_W-1:0] pick_elapsed();
      int sel;
      sel = $urandom_range(19);
      if (sel == 0) return '0;
      if (sel == 1) return MS_MAX;
      if (sel == 2) return MS_W'($urandom);
      return MS_W'($urandom_range(12));
   endfunction

   function automatic logic [MS_W-1:0] pick_limit();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return '0;
      if (sel == 9) return MS_MAX;
      return MS_W'($urandom_range(40));
   endfunction

   function automatic logic [SET_W-1:0] random_setting();
      logic [SET_W-1:0] s;
      s = '0;
      s[SET_CONFIRM_LSB +: MS_W] = pick_limit();
      s[SET_RECOVER_LSB +: MS_W] = pick_limit();
      s[SET_SEV_LSB +: SEV_W] = SEV_W'($urandom_range(3));
      s[SET_LATCH_BIT] = 1'($urandom_range(1));
      return s;
   endfunction

   function automatic request_type random_probe(logic [CH_W-1:0] chan);
      return pack_request(REQ_PROBE, chan, ($urandom_range(99) >= 45), $urandom,
                          pick_elapsed());
   endfunction

   // one request, with an optional random gap before it
   task automatic send_request(input request_type r);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_channel_index <= r.chan;
      req_healthy <= r.healthy;
      req_probe_detail <= r.detail;
      req_elapsed_ms <= r.elapsed;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(forecast_response(r));
      req_total++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [SET_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLE: monitor_on = val[0];
         CSR_COUNT: chan_in_use = val[CNT_W-1:0];
         default: chan_setting[idx - CSR_SETTING0] = val;
      endcase
      csr_total++;
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic test_reset_defaults();
      send_request(pack_request(REQ_PROBE, 3'd0, 1'b0, 32'h1234_5678, 24'd5));
      send_request(pack_request(REQ_QUERY, 3'd5, 1'b0, '0, '0));
      send_request(pack_request(REQ_CLEAR, 3'd2, 1'b1, '0, '0));
      send_request(pack_request(REQ_RESERVED, 3'd1, 1'b0, '0, '0));
      send_request(pack_request(REQ_PROBE, 3'd6, 1'b0, '1, MS_MAX));
      send_request(pack_request(REQ_QUERY, 3'd7, 1'b1, '0, '0));
   endtask

   task automatic test_debounce_directed();
      settle_idle();
      write_register(CSR_ENABLE, SET_W'(1));
      write_register(CSR_COUNT, SET_W'(6));
      write_register(CSR_SETTING0, {1'b1, 2'd3, 24'd0, 24'd0});
      write_register(CSR_SETTING0 + 3'd1, {1'b0, 2'd1, 24'd5, 24'd10});
      write_register(CSR_SETTING0 + 3'd2, {1'b1, 2'd2, MS_MAX, MS_MAX});
      csr_valid <= 1'b0;
      phase_total++;
      // zero confirm time activates at once
      send_request(pack_request(REQ_PROBE, 3'd0, 1'b0, '0, '0));
      send_request(pack_request(REQ_PROBE, 3'd1, 1'b0, '1, 24'd4));
      send_request(pack_request(REQ_PROBE, 3'd1, 1'b0, 32'hA5A5_5A5A, 24'd6));
      send_request(pack_request(REQ_PROBE, 3'd2, 1'b0, 32'h5A5A_A5A5, MS_MAX));
      send_request(pack_request(REQ_PROBE, 3'd2, 1'b0, 32'h0F0F_F0F0, MS_MAX));
      send_request(pack_request(REQ_PROBE, 3'd5, 1'b1, 32'hF0F0_0F0F, '0));
      // clear latch refused while active
      send_request(pack_request(REQ_CLEAR, 3'd0, 1'b0, '0, '0));
      send_request(pack_request(REQ_PROBE, 3'd0, 1'b1, 32'h1, '0));
      send_request(pack_request(REQ_CLEAR, 3'd0, 1'b0, '0, '0));
      send_request(pack_request(REQ_PROBE, 3'd2, 1'b1, 32'h2, MS_MAX));
      send_request(pack_request(REQ_PROBE, 3'd2, 1'b1, 32'h3, MS_MAX));
      // out of order reports push the tick count to saturation
      repeat (7) send_request(pack_request(REQ_PROBE, 3'd1, 1'b0, $urandom, 24'd1));
   endtask

   task automatic test_channel_count_limits();
      settle_idle();
      write_register(CSR_COUNT, SET_W'(0));
      csr_valid <= 1'b0;
      send_request(pack_request(REQ_QUERY, 3'd0, 1'b0, '0, '0));
      settle_idle();
      write_register(CSR_COUNT, SET_W'(7));
      csr_valid <= 1'b0;
      send_request(pack_request(REQ_PROBE, 3'd5, 1'b0, $urandom, 24'd3));
   endtask

   task automatic run_random_phase(input int items, input logic on, input logic [CNT_W-1:0] count);
      int sent;
      int used;
      int pick;
      settle_idle();
      write_register(CSR_ENABLE, SET_W'(on));
      write_register(CSR_COUNT, SET_W'(count));
      for (int c = 0; c < NUM_CH; c++) write_register(CSR_IDX_W'(CSR_SETTING0 + c),
                                                     random_setting());
      csr_valid <= 1'b0;
      phase_total++;
      used = (count > NUM_CH) ? NUM_CH : count;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            for (int c = 0; c < used; c++) begin
               send_request(random_probe(CH_W'(c)));
               sent++;
            end
         end else if (pick < 85) begin
            send_request(pack_request(REQ_CLEAR, CH_W'($urandom_range(7)),
                                      1'($urandom_range(1)), $urandom, pick_elapsed()));
            sent++;
         end else if (pick < 92) begin
            send_request(pack_request(REQ_QUERY, CH_W'($urandom_range(7)),
                                      1'($urandom_range(1)), $urandom, pick_elapsed()));
            sent++;
         end else if (pick < 95) begin
            send_request(pack_request(REQ_RESERVED, CH_W'($urandom_range(7)),
                                      1'($urandom_range(1)), $urandom, pick_elapsed()));
            sent++;
         end else begin
            send_request(random_probe(CH_W'($urandom_range(7))));
            sent++;
         end
      end
   endtask

   task automatic test_random_ticks();
      run_random_phase(400, 1'b1, 3'd6);
      run_random_phase(150, 1'b1, 3'd1);
      calm = 1'b1;
      run_random_phase(200, 1'b1, 3'd3);
      calm = 1'b0;
      run_random_phase(250, 1'b1, 3'd7);
      run_random_phase(50, 1'b1, 3'd0);
      run_random_phase(60, 1'b0, 3'd4);
      run_random_phase(350, 1'b1, 3'd5);
   endtask

   // response checking and random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("response with no request pending on channel %0d", rsp_out_channel);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("out_channel", want.chan, rsp_out_channel);
            check_field("status", want.status, rsp_status);
            check_field("fault_active", want.active, rsp_fault_active);
            check_field("latch_set", want.latched, rsp_latch_set);
            check_field("occurrences", want.occ, rsp_occurrences);
            check_field("stored_detail", want.detail, rsp_stored_detail);
            check_field("fault_time", want.fault_ms, rsp_fault_time);
            check_field("recovery_time", want.recover_ms, rsp_recovery_time);
            check_field("state_changed", want.changed, rsp_state_changed);
            check_field("active_total", want.total, rsp_active_total);
            check_field("top_severity", want.peak, rsp_top_severity);
            check_field("tick_done", want.done, rsp_tick_done);
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      monitor_on = 1'b0;
      chan_in_use = COUNT_RESET;
      tick_active = '0;
      tick_peak = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         chan_setting[c] = '0;
         active_flag[c] = 1'b0;
         latch_flag[c] = 1'b0;
         occ_count[c] = '0;
         detail_reg[c] = '0;
         fault_ms[c] = '0;
         recover_ms[c] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_debounce_directed();
      test_channel_count_limits();
      test_random_ticks();
      settle_idle();
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d responses never arrived", expected_q.size());
         fail_count++;
      end
      $display("covered %0d requests and %0d register writes over %0d configurations",
               req_total, csr_total, phase_total);
      $display("%0d mismatches found", fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fdm_pkg.sv
rtl/fdm_csr.sv
rtl/fdm_ctrl.sv
rtl/fdm_datapath.sv
rtl/fault_debounce_monitor.sv
tb/testbench.sv
